FILE: rtl/core/isp_pkg.sv
`timescale 1ns / 1ps

package isp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int PITCH_W    = 24;
    localparam int LEN_W      = 17;
    localparam int START_W    = 32;
    localparam int OFFSET_W   = 33;
    localparam int ADDR_IN_W  = 16;
    localparam int LIMIT_W    = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_OFFSET    = 3'd5;

    localparam logic signed [PITCH_W-1:0] PITCH_RST = 24'sd65536;
    localparam logic [GAIN_W-1:0]         GAIN_RST  = 16'd16384;
    localparam logic [LEN_W-1:0]          LEN_RST   = 17'd65536;

    // one-shot position limits
    localparam logic signed [LIMIT_W-1:0] LIMIT_HI = 33'sh0_FFFF_FFFF;
    localparam logic signed [LIMIT_W-1:0] LIMIT_LO = 33'sh1_0000_0000;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_READ    = 2'd1,
        MODE_ADVANCE = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode                       mode;
        logic [ADDR_IN_W-1:0]        sample_address;
        logic signed [SAMPLE_W-1:0]  sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  sample_out;
        logic                        in_range;
    } t_out_item;

endpackage

FILE: rtl/core/isp_in_if.sv
`timescale 1ns / 1ps

interface isp_in_if;
    logic              valid;
    logic              ready;
    isp_pkg::t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/isp_out_if.sv
`timescale 1ns / 1ps

interface isp_out_if;
    logic               valid;
    logic               ready;
    isp_pkg::t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/interpolating_sample_player.sv
`timescale 1ns / 1ps

// One sample-playback voice around a single synchronous sample store. A load item writes
// one sample. A one-shot read whose position lies in the sound goes through two store
// reads, the interpolation multiply, the gain multiply, then round and saturate; one outside
// the sound goes straight to a silent result. In loop mode the position is reduced modulo
// the sound length by a bit-serial remainder unit of IW steps, IW = max(34, FRACTION_BITS
// + 19) - FRACTION_BITS (19 at the defaults), before the advance or read goes on. One
// item is in work at a time; the result sits in an output register, so the next item is
// taken while the last result waits.
module interpolating_sample_player #(
    parameter int STORE_DEPTH   = 65536,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [isp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [isp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    isp_in_if.sink                             i_in,
    isp_out_if.source                          o_out
);

    localparam int F     = FRACTION_BITS;
    localparam int LW    = isp_pkg::LEN_W;
    localparam int SMW   = isp_pkg::SAMPLE_W;
    localparam int AW    = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW    = (AW + 1 > LW) ? AW + 1 : LW;
    localparam int ACW   = ((AW > isp_pkg::ADDR_IN_W) ? AW : isp_pkg::ADDR_IN_W) + 1;
    localparam int PW    = (LW + F + 1 > isp_pkg::LIMIT_W) ? LW + F + 1 : isp_pkg::LIMIT_W;
    localparam int SW    = PW + 1;
    localparam int IW    = SW - F;
    localparam int XW    = (IW > CW) ? IW : CW;
    localparam int CNT_W = $clog2(IW + 1);
    localparam int PPW   = SMW + F + 2;
    localparam int GPW   = PPW + isp_pkg::GAIN_W + 1;
    localparam int RSH   = F + 14;
    localparam int OW    = GPW - RSH;

    localparam logic signed [SW-1:0] POS_HI = SW'(isp_pkg::LIMIT_HI);
    localparam logic signed [SW-1:0] POS_LO = SW'(isp_pkg::LIMIT_LO);
    localparam logic signed [OW-1:0] Q_MAX  = OW'(32'sd32767);
    localparam logic signed [OW-1:0] Q_MIN  = OW'(-32'sd32768);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_FIX,
        S_RD_A,
        S_RD_B,
        S_MUL1,
        S_MUL2,
        S_OUT
    } t_state;

    // configuration
    logic signed [isp_pkg::PITCH_W-1:0]  r_pitch_step;
    logic [isp_pkg::GAIN_W-1:0]          r_gain;
    logic                                r_loop;
    logic [LW-1:0]                       r_sound_length;
    logic signed [isp_pkg::OFFSET_W-1:0] r_read_offset;

    // datapath and control
    t_state                  r_state;
    logic signed [PW-1:0]    r_pos;
    logic [F-1:0]            r_frac;
    logic                    r_is_read;
    logic                    r_neg;
    logic [IW-1:0]           r_mag;
    logic [LW-1:0]           r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic [AW-1:0]           r_idx;
    logic                    r_b_zero;
    logic                    r_silent;
    logic signed [SMW-1:0]   r_a;
    logic signed [PPW-1:0]   r_p;
    logic signed [GPW-1:0]   r_prod;
    logic                    r_out_valid;
    isp_pkg::t_out_item      r_out;

    logic [SMW-1:0]          mem [STORE_DEPTH];
    logic [SMW-1:0]          r_rdata;

    logic                    w_in_xfer;
    logic [LW-1:0]           w_len;
    logic signed [SW-1:0]    w_eff;
    logic signed [SW-1:0]    w_adv;
    logic signed [SW-1:0]    w_sum;
    logic signed [SW-1:0]    w_clamped;
    logic signed [IW-1:0]    w_int;
    logic [IW-1:0]           w_mag;
    logic                    w_oneshot_out;
    logic [LW:0]             w_cand;
    logic [LW-1:0]           w_rem_next;
    logic [LW-1:0]           w_mod;
    logic [CW-1:0]           w_next;
    logic                    w_inc_ok;
    logic                    w_we;
    logic [AW-1:0]           w_raddr;
    logic signed [SMW-1:0]   w_b;
    logic signed [SMW:0]     w_diff;
    logic signed [PPW-1:0]   w_p;
    logic signed [GPW-1:0]   w_rnd;
    logic signed [OW-1:0]    w_q;
    logic signed [SMW-1:0]   w_sat;

    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // active sound length: zero acts as one, clipped to the store
    always_comb begin
        if (r_sound_length == '0) begin
            w_len = LW'(1);
        end else if (CW'(r_sound_length) > CW'(STORE_DEPTH)) begin
            w_len = LW'(STORE_DEPTH);
        end else begin
            w_len = r_sound_length;
        end
    end

    assign w_eff = SW'(r_pos) + SW'(r_read_offset);
    assign w_adv = SW'(r_pos) + SW'(r_pitch_step);
    assign w_sum = (i_in.data.mode == isp_pkg::MODE_READ) ? w_eff : w_adv;
    assign w_int = w_sum[SW-1:F];
    assign w_mag = w_int[IW-1] ? (~w_int + IW'(1)) : w_int;

    assign w_oneshot_out = w_eff[SW-1] || (XW'(w_mag) >= XW'(w_len));

    always_comb begin
        if (w_adv > POS_HI) begin
            w_clamped = POS_HI;
        end else if (w_adv < POS_LO) begin
            w_clamped = POS_LO;
        end else begin
            w_clamped = w_adv;
        end
    end

    // restoring remainder, one integer bit per cycle
    assign w_cand     = {r_rem, r_mag[IW-1]};
    assign w_rem_next = (w_cand >= {1'b0, w_len}) ? LW'(w_cand - {1'b0, w_len}) : LW'(w_cand);
    assign w_mod      = (r_neg && r_rem != '0) ? (w_len - r_rem) : r_rem;

    // right neighbour
    assign w_next   = CW'(r_idx) + CW'(1);
    assign w_inc_ok = w_next < CW'(w_len);

    assign w_we = w_in_xfer && (i_in.data.mode == isp_pkg::MODE_LOAD)
                  && (ACW'(i_in.data.sample_address) < ACW'(STORE_DEPTH));
    assign w_raddr = (r_state == S_RD_B) ? (w_inc_ok ? AW'(w_next) : '0) : r_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[AW'(i_in.data.sample_address)] <= i_in.data.sample_value;
        end
        r_rdata <= mem[w_raddr];
    end

    // interpolation and gain
    assign w_b    = r_b_zero ? '0 : $signed(r_rdata);
    assign w_diff = (SMW + 1)'(w_b) - (SMW + 1)'(r_a);
    assign w_p    = (PPW'(r_a) <<< F) + PPW'(w_diff) * PPW'($signed({1'b0, r_frac}));
    assign w_rnd  = r_prod + (GPW'(1) <<< (F + 13));
    assign w_q    = w_rnd[GPW-1:RSH];

    always_comb begin
        if (w_q > Q_MAX) begin
            w_sat = SMW'(Q_MAX);
        end else if (w_q < Q_MIN) begin
            w_sat = SMW'(Q_MIN);
        end else begin
            w_sat = SMW'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_step   <= isp_pkg::PITCH_RST;
            r_gain         <= isp_pkg::GAIN_RST;
            r_loop         <= 1'b0;
            r_sound_length <= isp_pkg::LEN_RST;
            r_read_offset  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                isp_pkg::REG_PITCH_STEP: begin
                    r_pitch_step <= i_cfg_data[isp_pkg::PITCH_W-1:0];
                end
                isp_pkg::REG_GAIN: begin
                    r_gain <= i_cfg_data[isp_pkg::GAIN_W-1:0];
                end
                isp_pkg::REG_LOOP_ENABLE: begin
                    r_loop <= i_cfg_data[0];
                end
                isp_pkg::REG_SOUND_LENGTH: begin
                    r_sound_length <= i_cfg_data[LW-1:0];
                end
                isp_pkg::REG_READ_OFFSET: begin
                    r_read_offset <= i_cfg_data[isp_pkg::OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == isp_pkg::REG_START_POSITION) begin
                r_pos <= PW'(i_cfg_data[isp_pkg::START_W-1:0]);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        case (i_in.data.mode)
                            isp_pkg::MODE_READ: begin
                                r_frac    <= w_eff[F-1:0];
                                r_is_read <= 1'b1;
                                r_silent  <= 1'b0;
                                if (r_loop) begin
                                    r_neg   <= w_int[IW-1];
                                    r_mag   <= w_mag;
                                    r_rem   <= '0;
                                    r_cnt   <= CNT_W'(IW);
                                    r_state <= S_MOD;
                                end else if (w_oneshot_out) begin
                                    r_silent <= 1'b1;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_idx   <= AW'(w_mag);
                                    r_state <= S_RD_A;
                                end
                            end
                            isp_pkg::MODE_ADVANCE: begin
                                r_frac    <= w_adv[F-1:0];
                                r_is_read <= 1'b0;
                                if (r_loop) begin
                                    r_neg   <= w_int[IW-1];
                                    r_mag   <= w_mag;
                                    r_rem   <= '0;
                                    r_cnt   <= CNT_W'(IW);
                                    r_state <= S_MOD;
                                end else begin
                                    r_pos <= PW'(w_clamped);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    r_mag <= r_mag << 1;
                    r_rem <= w_rem_next;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_is_read) begin
                        r_idx   <= AW'(w_mod);
                        r_state <= S_RD_A;
                    end else begin
                        r_pos   <= PW'({w_mod, r_frac});
                        r_state <= S_IDLE;
                    end
                end
                S_RD_A: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_a      <= r_rdata;
                    r_b_zero <= !w_inc_ok && !r_loop;
                    r_state  <= S_MUL1;
                end
                S_MUL1: begin
                    r_p     <= w_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= GPW'(r_p) * GPW'($signed({1'b0, r_gain}));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.sample_out    <= r_silent ? '0 : w_sat;
                        r_out.in_range      <= !r_silent;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_mod_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOD |-> r_cnt != '0)
        else $error("remainder unit running with an empty step count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIX |-> r_rem < w_len)
        else $error("remainder not below the sound length");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.data.mode != isp_pkg::MODE_READ && !r_out_valid)
        |=> !r_out_valid)
        else $error("result raised by a load or advance transfer");

    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.in_range) |-> r_out.sample_out == '0)
        else $error("out-of-range result is not silent");

endmodule
